@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/pbsd_pkg.sv @@
`default_nettype none

package pbsd_pkg;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam logic REG_SEGMENT_LENGTH = 1'b0;   // register index, paddr[2]
    localparam logic [31:0] SEGMENT_LENGTH_RESET = 32'd1;

    // Header byte that is skipped
    localparam logic [7:0] SKIP_HEADER = 8'h80;

    // Result queue depth (two words may enter per cycle)
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_LITERAL = 2'd1,
        MODE_REPEAT  = 2'd2,
        MODE_FULL    = 2'd3
    } mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       segment_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  out_value;
        logic [31:0] repeat_count;
        logic [31:0] out_position;
        logic        missing_data;
        logic        segment_last;
    } out_word_t;

    // Words handed from the decoder to the result queue in one cycle
    typedef struct packed {
        logic      first_valid;
        logic      second_valid;
        out_word_t first;
        out_word_t second;
    } push_t;

endpackage

`default_nettype wire

@@ rtl/pbsd_core.sv @@
`default_nettype none

module pbsd_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             take,
    input  wire pbsd_pkg::in_word_t in_word,
    input  wire logic [31:0]      segment_length,
    output pbsd_pkg::push_t       push
);
    import pbsd_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [7:0]  run_reg, run_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] pos_reg, pos_next;
    logic        fresh_reg, fresh_next;

    // State seen by this word, after the start-of-segment load
    mode_t       mode_eff;
    logic [7:0]  run_eff;
    logic [31:0] rem_eff;
    logic [31:0] pos_eff;

    logic [31:0] run_wide;
    logic [31:0] rep_count;
    logic [31:0] adv;
    logic [31:0] rem_adv;
    logic [31:0] pos_adv;
    logic        data_item;
    out_word_t   data_word;
    out_word_t   final_word;

    // Start of segment: load length, clear position and run
    always_comb
    begin
        if (fresh_reg)
        begin
            rem_eff  = segment_length;
            pos_eff  = '0;
            run_eff  = '0;
            mode_eff = (segment_length == '0) ? MODE_FULL : MODE_HEADER;
        end
        else
        begin
            rem_eff  = rem_reg;
            pos_eff  = pos_reg;
            run_eff  = run_reg;
            mode_eff = mode_reg;
        end
    end

    // Run length clipped to what the segment still owes
    assign run_wide  = {24'd0, run_eff};
    assign rep_count = (run_wide > rem_eff) ? rem_eff : run_wide;
    assign adv       = (mode_eff == MODE_LITERAL) ? 32'd1 : rep_count;
    assign rem_adv   = rem_eff - adv;
    assign pos_adv   = pos_eff + adv;

    // Next state and result words
    always_comb
    begin
        mode_next  = mode_eff;
        run_next   = run_eff;
        rem_next   = rem_eff;
        pos_next   = pos_eff;
        fresh_next = 1'b0;
        data_item  = 1'b0;

        data_word.out_value    = in_word.data_byte;
        data_word.repeat_count = adv;
        data_word.out_position = pos_eff;
        data_word.missing_data = 1'b0;
        data_word.segment_last = 1'b0;

        case (mode_eff)
            MODE_HEADER:
            begin
                if (!in_word.segment_end)
                begin
                    if (!in_word.data_byte[7])
                    begin
                        run_next  = in_word.data_byte + 8'd1;
                        mode_next = MODE_LITERAL;
                    end
                    else if (in_word.data_byte != SKIP_HEADER)
                    begin
                        run_next  = 8'd1 - in_word.data_byte;
                        mode_next = MODE_REPEAT;
                    end
                end
            end
            MODE_LITERAL:
            begin
                data_item = 1'b1;
                run_next  = run_eff - 8'd1;
                rem_next  = rem_adv;
                pos_next  = pos_adv;
                if (rem_adv == '0)
                    mode_next = MODE_FULL;
                else if (run_eff == 8'd1)
                    mode_next = MODE_HEADER;
                else
                    mode_next = MODE_LITERAL;
            end
            MODE_REPEAT:
            begin
                data_item = 1'b1;
                run_next  = '0;
                rem_next  = rem_adv;
                pos_next  = pos_adv;
                mode_next = (rem_adv == '0) ? MODE_FULL : MODE_HEADER;
            end
            default:
            begin
                mode_next = MODE_FULL;
            end
        endcase

        // Closing word; a short segment reports a zero fill
        final_word.out_value    = 8'd0;
        final_word.repeat_count = rem_next;
        final_word.out_position = pos_next;
        final_word.missing_data = (rem_next != '0);
        final_word.segment_last = 1'b1;

        if (in_word.segment_end)
        begin
            fresh_next = 1'b1;
            mode_next  = MODE_HEADER;
            run_next   = '0;
        end
    end

    // Words to the result queue, data word first
    always_comb
    begin
        push.first_valid  = take && (data_item || in_word.segment_end);
        push.second_valid = take && data_item && in_word.segment_end;
        push.first        = data_item ? data_word : final_word;
        push.second       = final_word;
    end

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_HEADER;
            run_reg   <= '0;
            rem_reg   <= '0;
            pos_reg   <= '0;
            fresh_reg <= 1'b1;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            run_reg   <= run_next;
            rem_reg   <= rem_next;
            pos_reg   <= pos_next;
            fresh_reg <= fresh_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pbsd_fifo.sv @@
`default_nettype none

module pbsd_fifo #(
    parameter int Depth = pbsd_pkg::FIFO_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pbsd_pkg::push_t    push,
    output logic                    room,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output pbsd_pkg::out_word_t     out_word
);
    import pbsd_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] RoomLimit = CntW'(Depth - 2);

    out_word_t       slot_reg [Depth];
    logic [PtrW-1:0] wptr_reg, wptr_next;
    logic [PtrW-1:0] wptr_plus1;
    logic [PtrW-1:0] rptr_reg, rptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            pop;
    logic [1:0]      push_n;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        ptr_inc = (p == LastPtr) ? '0 : p + PtrW'(1);
    endfunction

    assign pop        = out_valid && !out_stall;
    assign push_n     = {1'b0, push.first_valid} + {1'b0, push.second_valid};
    assign wptr_plus1 = ptr_inc(wptr_reg);

    // Pointers and fill level
    always_comb
    begin
        case (push_n)
            2'd1:    wptr_next = wptr_plus1;
            2'd2:    wptr_next = ptr_inc(wptr_plus1);
            default: wptr_next = wptr_reg;
        endcase
        rptr_next  = pop ? ptr_inc(rptr_reg) : rptr_reg;
        count_next = count_reg + CntW'(push_n) - CntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Slot storage, up to two words written per cycle
    always_ff @(posedge clk)
    begin
        if (push.first_valid)
            slot_reg[wptr_reg] <= push.first;
        if (push.second_valid)
            slot_reg[wptr_plus1] <= push.second;
    end

    // Room for two words means a new input byte may be taken
    assign room      = (count_reg <= RoomLimit);
    assign out_valid = (count_reg != '0);
    assign out_word  = slot_reg[rptr_reg];

endmodule

`default_nettype wire

@@ rtl/packbits_segment_decoder.sv @@
`default_nettype none
// Channel    | Handshake              | Word
// -----------+------------------------+--------------------------------------
// byte_*     | byte_valid, byte_stall | in_word_t: data_byte, segment_end
// run_*      | run_valid, run_stall   | out_word_t: value, count, position, flags
// APB        | psel, penable, pready  | segment_length at byte address 0
//
// One compressed byte is taken per cycle unless byte_stall is high; the decoder state
// updates in a single pass. A byte that carries segment_end may yield two result
// words, both queued together; the result queue lets input continue meanwhile.
// byte_stall rises when the result queue has fewer than two free slots.
// Reset clears the decoder state and queue; segment_length resets to 1.

module packbits_segment_decoder #(
    parameter int FifoDepth = pbsd_pkg::FIFO_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            byte_valid,
    output logic                                 byte_stall,
    input  wire pbsd_pkg::in_word_t              byte_data,
    output logic                                 run_valid,
    input  wire logic                            run_stall,
    output pbsd_pkg::out_word_t                  run_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pbsd_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import pbsd_pkg::*;

    logic [31:0] seg_len_reg;
    logic        take;
    logic        room;
    push_t       push;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_len_reg <= SEGMENT_LENGTH_RESET;
        else if (psel && penable && pwrite && (paddr[2] == REG_SEGMENT_LENGTH))
            seg_len_reg <= pwdata;
    end

    assign prdata = (paddr[2] == REG_SEGMENT_LENGTH) ? seg_len_reg : '0;

    // Input handshake
    assign byte_stall = !room;
    assign take       = byte_valid && room;

    pbsd_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .in_word        (byte_data),
        .segment_length (seg_len_reg),
        .push           (push)
    );

    pbsd_fifo #(
        .Depth (FifoDepth)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (run_valid),
        .out_stall (run_stall),
        .out_word  (run_data)
    );

endmodule

`default_nettype wire

@@ rtl/pbsd_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module pbsd_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                run_valid,
    input wire logic                run_stall,
    input wire pbsd_pkg::out_word_t run_data
);

    // A stalled result word holds
    `ASSERT_NEXT(a_run_hold, clk, rst_n, run_valid && run_stall, run_valid && $stable(run_data))

    // Only the closing word may be empty
    `ASSERT_IMPLIES(a_empty_is_last, clk, rst_n, run_valid && (run_data.repeat_count == '0), run_data.segment_last)

    // Zero fill comes only on the closing word and always covers something
    `ASSERT_IMPLIES(a_fill_is_last, clk, rst_n, run_valid && run_data.missing_data, run_data.segment_last && (run_data.repeat_count != '0))

    // The closing word carries a zero value
    `ASSERT_IMPLIES(a_last_zero, clk, rst_n, run_valid && run_data.segment_last, run_data.out_value == 8'd0)

endmodule

bind packbits_segment_decoder pbsd_checker u_pbsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_valid (run_valid),
    .run_stall (run_stall),
    .run_data  (run_data)
);

`default_nettype wire
